// ===== sv/alu_hr_pkg.sv =====
package alu_hr_pkg;

    // History size and derived widths.
    localparam int HISTORY_DEPTH = 10;
    localparam int SLOT_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

    // Fixed field widths.
    localparam int DATA_W = 32;
    localparam int CMD_W  = 2;
    localparam int OP_W   = 3;
    localparam int IDX_W  = 8;
    localparam int ST_W   = 3;
    localparam int POS_W  = 7;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REPLAY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_LIST    = 2'd3;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;
    localparam logic [OP_W-1:0] OP_REM = 3'd4;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_OK     = 3'd0;
    localparam logic [ST_W-1:0] ST_DIV0   = 3'd1;
    localparam logic [ST_W-1:0] ST_REM0   = 3'd2;
    localparam logic [ST_W-1:0] ST_BADIDX = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY  = 3'd4;
    localparam logic [ST_W-1:0] ST_DONE   = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
        logic [OP_W-1:0]          op_code;
        logic [IDX_W-1:0]         replay_index;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [ST_W-1:0]          status;
        logic signed [DATA_W-1:0] entry_a;
        logic [OP_W-1:0]          entry_op;
        logic signed [DATA_W-1:0] entry_b;
        logic [POS_W-1:0]         entry_pos;
        logic                     last;
    } t_out_beat;

    // One stored history entry, also the request to the arithmetic unit.
    typedef struct packed {
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic [OP_W-1:0]          op;
    } t_alu_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [ST_W-1:0]          status;
    } t_alu_rsp;

    typedef struct packed {
        logic signed [DATA_W-1:0] quot;
        logic signed [DATA_W-1:0] rem;
    } t_div_rsp;

endpackage

// ===== sv/alu_hr_ram.sv =====
module alu_hr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/alu_hr_div.sv =====
module alu_hr_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [alu_hr_pkg::DATA_W-1:0] i_a,
    input  logic signed [alu_hr_pkg::DATA_W-1:0] i_b,
    output logic                             o_done,
    output alu_hr_pkg::t_div_rsp             o_rsp
);
    import alu_hr_pkg::*;

    localparam int STEP_W = $clog2(DATA_W);

    logic              r_busy, n_busy;
    logic              r_fin, n_fin;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [DATA_W-1:0] r_quo, n_quo;
    logic [DATA_W-1:0] r_dvs, n_dvs;
    logic              r_neg_q, n_neg_q;
    logic              r_neg_r, n_neg_r;

    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   diff;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign rem_sh = {r_rem, r_quo[DATA_W-1]};
    assign diff   = rem_sh - {1'b0, r_dvs};

    always_comb begin
        n_busy  = r_busy;
        n_fin   = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        n_neg_q = r_neg_q;
        n_neg_r = r_neg_r;
        if (i_start) begin
            // Work on magnitudes; the minimum value maps to its unsigned magnitude.
            n_busy  = 1'b1;
            n_cnt   = '0;
            n_rem   = '0;
            n_quo   = i_a[DATA_W-1] ? DATA_W'(-i_a) : DATA_W'(i_a);
            n_dvs   = i_b[DATA_W-1] ? DATA_W'(-i_b) : DATA_W'(i_b);
            n_neg_q = i_a[DATA_W-1] ^ i_b[DATA_W-1];
            n_neg_r = i_a[DATA_W-1];
        end else if (r_busy) begin
            if (!diff[DATA_W]) begin
                n_rem = diff[DATA_W-1:0];
                n_quo = {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[DATA_W-1:0];
                n_quo = {r_quo[DATA_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + STEP_W'(1);
            if (r_cnt == STEP_W'(DATA_W - 1)) begin
                n_busy = 1'b0;
                n_fin  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_fin  <= n_fin;
        end
        r_cnt   <= n_cnt;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_dvs   <= n_dvs;
        r_neg_q <= n_neg_q;
        r_neg_r <= n_neg_r;
    end

    // Signs are restored on the way out; quotient wraps for minimum by minus one.
    assign o_done     = r_fin;
    assign o_rsp.quot = r_neg_q ? -$signed(r_quo) : $signed(r_quo);
    assign o_rsp.rem  = r_neg_r ? -$signed(r_rem) : $signed(r_rem);

endmodule

// ===== sv/alu_hr_alu.sv =====
module alu_hr_alu (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  alu_hr_pkg::t_alu_req i_req,
    output logic                 o_done,
    output alu_hr_pkg::t_alu_rsp o_rsp
);
    import alu_hr_pkg::*;

    logic                     r_done, n_done;
    logic                     r_wait, n_wait;
    logic                     r_is_rem, n_is_rem;
    t_alu_rsp                 r_rsp, n_rsp;

    logic signed [DATA_W-1:0] mul_lo;
    logic                     div_start;
    logic                     div_done;
    t_div_rsp                 div_rsp;
    logic                     b_zero;

    assign mul_lo = i_req.a * i_req.b;
    assign b_zero = (i_req.b == '0);

    // Divide and remainder share the iterative divider.
    assign div_start = i_start && (i_req.op != OP_ADD) && (i_req.op != OP_SUB)
                       && (i_req.op != OP_MUL) && !b_zero;

    alu_hr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_a     (i_req.a),
        .i_b     (i_req.b),
        .o_done  (div_done),
        .o_rsp   (div_rsp)
    );

    // Add, subtract, multiply and zero divisors finish at once; divide and remainder wait for the divider.
    always_comb begin
        n_done   = 1'b0;
        n_wait   = r_wait;
        n_is_rem = r_is_rem;
        n_rsp    = r_rsp;
        if (i_start) begin
            n_rsp.status = ST_OK;
            n_rsp.value  = '0;
            case (i_req.op)
                OP_ADD: begin
                    n_rsp.value = i_req.a + i_req.b;
                    n_done      = 1'b1;
                end
                OP_SUB: begin
                    n_rsp.value = i_req.a - i_req.b;
                    n_done      = 1'b1;
                end
                OP_MUL: begin
                    n_rsp.value = mul_lo;
                    n_done      = 1'b1;
                end
                OP_DIV: begin
                    n_is_rem = 1'b0;
                    if (b_zero) begin
                        n_rsp.status = ST_DIV0;
                        n_done       = 1'b1;
                    end else begin
                        n_wait = 1'b1;
                    end
                end
                default: begin
                    n_is_rem = 1'b1;
                    if (b_zero) begin
                        n_rsp.status = ST_REM0;
                        n_done       = 1'b1;
                    end else begin
                        n_wait = 1'b1;
                    end
                end
            endcase
        end else if (r_wait && div_done) begin
            n_wait       = 1'b0;
            n_done       = 1'b1;
            n_rsp.status = ST_OK;
            n_rsp.value  = r_is_rem ? div_rsp.rem : div_rsp.quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_wait <= 1'b0;
        end else begin
            r_done <= n_done;
            r_wait <= n_wait;
        end
        r_is_rem <= n_is_rem;
        r_rsp    <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ===== sv/alu_with_history_replay.sv =====
// Command ALU with a replayable history of its last HISTORY_DEPTH computations.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one command beat:
// compute, replay, clear or list. Output channel (o_out_valid / i_out_ready /
// o_out_data) returns result beats; the final beat of a command has last set.
// One command is worked on at a time; o_in_ready is high whenever no command
// is in progress, even while a finished result still waits in the output register.
// A compute result passes through the arithmetic unit's result register, the
// pending beat and the output register; clear, bad index and empty list skip the
// arithmetic unit, and divide or remainder waits for a 32-step restoring divider.
// Replay adds a history memory read. A list emits one beat per entry; each entry
// is read, recomputed and handed out before the next entry is read.
// The history lives in one synchronous RAM; reset clears the entry count and
// ring pointer but not the RAM, so no clearing pass is needed.
// When the receiver stalls, the result is held in the output register and the
// next result waits in the block, which stops taking commands until it leaves.
module alu_with_history_replay (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  alu_hr_pkg::t_in_beat  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output alu_hr_pkg::t_out_beat o_out_data
);
    import alu_hr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam int HIST_W = $bits(t_alu_req);

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SLOT_W-1:0] r_oldest, n_oldest;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_last_pos, n_last_pos;
    logic              r_is_comp, n_is_comp;
    t_alu_req          r_entry, n_entry;
    t_out_beat         r_pend, n_pend;
    logic              r_out_valid, n_out_valid;
    t_out_beat         r_out, n_out;

    logic              in_acc;
    logic              out_free;
    logic              alu_start;
    t_alu_req          alu_req;
    logic              alu_done;
    t_alu_rsp          alu_rsp;
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [SLOT_W-1:0] ram_raddr;
    logic [HIST_W-1:0] ram_rdata;
    t_alu_req          ram_entry;
    logic [POS_W-1:0]  rd_pos;
    logic              hist_full;

    // Ring slot of a one-based history position.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] oldest,
                                                  input logic [POS_W-1:0] pos);
        logic [POS_W:0] sum;
        sum = (POS_W+1)'(oldest) + (POS_W+1)'(pos) - (POS_W+1)'(1);
        if (sum >= (POS_W+1)'(HISTORY_DEPTH)) begin
            sum = sum - (POS_W+1)'(HISTORY_DEPTH);
        end
        return sum[SLOT_W-1:0];
    endfunction

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign hist_full  = (r_count == CNT_W'(HISTORY_DEPTH));
    assign ram_entry  = t_alu_req'(ram_rdata);

    // Read address: first or requested position on a new command, else the next one.
    always_comb begin
        if (r_state == S_IDLE) begin
            rd_pos = (i_in_data.cmd == CMD_LIST) ? POS_W'(1)
                                                  : i_in_data.replay_index[POS_W-1:0];
        end else begin
            rd_pos = r_pos + POS_W'(1);
        end
    end

    assign ram_raddr = slot_of(r_oldest, rd_pos);
    assign ram_waddr = hist_full ? r_oldest
                                 : slot_of(r_oldest, POS_W'(r_count) + POS_W'(1));

    alu_hr_ram #(
        .WIDTH (HIST_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_entry),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    alu_hr_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (alu_start),
        .i_req   (alu_req),
        .o_done  (alu_done),
        .o_rsp   (alu_rsp)
    );

    // Command sequencer.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_oldest    = r_oldest;
        n_pos       = r_pos;
        n_last_pos  = r_last_pos;
        n_is_comp   = r_is_comp;
        n_entry     = r_entry;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        alu_start   = 1'b0;
        alu_req     = r_entry;
        ram_we      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_pend = '0;
                    n_pend.last = 1'b1;
                    case (i_in_data.cmd)
                        CMD_COMPUTE: begin
                            // Opcodes without meaning are dropped silently.
                            if (i_in_data.op_code <= OP_REM) begin
                                alu_start   = 1'b1;
                                alu_req.a   = i_in_data.operand_a;
                                alu_req.b   = i_in_data.operand_b;
                                alu_req.op  = i_in_data.op_code;
                                n_entry     = alu_req;
                                n_is_comp   = 1'b1;
                                n_state     = S_EXEC;
                            end
                        end
                        CMD_REPLAY: begin
                            if ((i_in_data.replay_index == '0) ||
                                (i_in_data.replay_index > IDX_W'(r_count))) begin
                                n_pend.status = ST_BADIDX;
                                n_state       = S_EMIT;
                            end else begin
                                n_pos      = i_in_data.replay_index[POS_W-1:0];
                                n_last_pos = i_in_data.replay_index[POS_W-1:0];
                                n_is_comp  = 1'b0;
                                n_state    = S_READ;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count       = '0;
                            n_oldest      = '0;
                            n_pend.status = ST_DONE;
                            n_state       = S_EMIT;
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_pend.status = ST_EMPTY;
                                n_state       = S_EMIT;
                            end else begin
                                n_pos      = POS_W'(1);
                                n_last_pos = POS_W'(r_count);
                                n_is_comp  = 1'b0;
                                n_state    = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                // Stored entry is on the RAM output now; recompute it.
                alu_start = 1'b1;
                alu_req   = ram_entry;
                n_entry   = ram_entry;
                n_state   = S_EXEC;
            end
            S_EXEC: begin
                if (alu_done) begin
                    n_pend.value  = alu_rsp.value;
                    n_pend.status = alu_rsp.status;
                    if (r_is_comp) begin
                        n_pend.entry_a   = '0;
                        n_pend.entry_op  = '0;
                        n_pend.entry_b   = '0;
                        n_pend.entry_pos = '0;
                        n_pend.last      = 1'b1;
                        // Successful computes go into the ring, dropping the oldest when full.
                        if (alu_rsp.status == ST_OK) begin
                            ram_we = 1'b1;
                            if (hist_full) begin
                                n_oldest = (r_oldest == SLOT_W'(HISTORY_DEPTH - 1))
                                           ? '0 : r_oldest + SLOT_W'(1);
                            end else begin
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                    end else begin
                        n_pend.entry_a   = r_entry.a;
                        n_pend.entry_op  = r_entry.op;
                        n_pend.entry_b   = r_entry.b;
                        n_pend.entry_pos = r_pos;
                        n_pend.last      = (r_pos == r_last_pos);
                    end
                    n_state = S_EMIT;
                end
            end
            default: begin
                // Hand the pending beat to the output register, then continue a list.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_pend;
                    if (r_pend.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pos   = r_pos + POS_W'(1);
                        n_state = S_READ;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_oldest    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_oldest    <= n_oldest;
            r_out_valid <= n_out_valid;
        end
        r_pos      <= n_pos;
        r_last_pos <= n_last_pos;
        r_is_comp  <= n_is_comp;
        r_entry    <= n_entry;
        r_pend     <= n_pend;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The ring only rotates once the history is full.
    a_oldest_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oldest != '0) |-> (r_count == CNT_W'(HISTORY_DEPTH)))
        else $error("ring pointer moved while history not full");

    // A clear command leaves an empty history behind.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_data.cmd == CMD_CLEAR)) |=> (r_count == '0))
        else $error("history not empty after clear");

    // The arithmetic unit only finishes while the sequencer waits for it.
    a_alu_done_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_done |-> (r_state == S_EXEC))
        else $error("arithmetic result arrived outside execute state");

    // Error and status beats carry a zero value.
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_OK)) |-> (o_out_data.value == '0))
        else $error("non-zero value on a status beat");

endmodule

// ===== tb/tb_alu_with_history_replay.sv =====
module tb_alu_with_history_replay;
    timeunit 1ns;
    timeprecision 1ps;

    import alu_hr_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 120;
    localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_beat  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_beat o_out_data;

    // Predictor state: a ring of stored computations.
    t_alu_req  hist_ring [HISTORY_DEPTH];
    int        hist_head;
    int        hist_count;

    t_out_beat expected_beats[$];
    int        mismatches;
    int        beats_checked;
    int        cmd_seen [4];
    int        send_idle_pct;
    int        recv_idle_pct;
    int        quiet_cycles;

    alu_with_history_replay dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Arithmetic with 32-bit wrap; division is done in 64 bits so that the
    // minimum divided by minus one wraps instead of trapping.
    function automatic t_alu_rsp alu_result(logic signed [DATA_W-1:0] a,
                                            logic [OP_W-1:0] op,
                                            logic signed [DATA_W-1:0] b);
        t_alu_rsp r;
        longint   wide_a;
        longint   wide_b;
        wide_a = a;
        wide_b = b;
        r.value = '0;
        r.status = ST_OK;
        case (op)
            OP_ADD: r.value = a + b;
            OP_SUB: r.value = a - b;
            OP_MUL: r.value = a * b;
            OP_DIV: begin
                if (b == 0) r.status = ST_DIV0;
                else r.value = 32'(wide_a / wide_b);
            end
            default: begin
                if (b == 0) r.status = ST_REM0;
                else r.value = 32'(wide_a % wide_b);
            end
        endcase
        return r;
    endfunction

    function automatic t_out_beat status_beat(logic [ST_W-1:0] st);
        t_out_beat o;
        o = '0;
        o.status = st;
        o.last = 1'b1;
        return o;
    endfunction

    // Recomputed beat for the stored entry at a 1-based position.
    function automatic t_out_beat entry_beat(int pos, logic is_last);
        t_out_beat o;
        t_alu_req  e;
        t_alu_rsp  r;
        e = hist_ring[(hist_head + pos - 1) % HISTORY_DEPTH];
        r = alu_result(e.a, e.op, e.b);
        o.value = r.value;
        o.status = r.status;
        o.entry_a = e.a;
        o.entry_op = e.op;
        o.entry_b = e.b;
        o.entry_pos = POS_W'(pos);
        o.last = is_last;
        return o;
    endfunction

    // Update the history model and queue the beats that a command produces.
    task automatic predict_results(t_in_beat c);
        t_alu_rsp r;
        t_out_beat o;
        cmd_seen[c.cmd]++;
        case (c.cmd)
            CMD_COMPUTE: begin
                if (c.op_code <= OP_REM) begin
                    r = alu_result(c.operand_a, c.op_code, c.operand_b);
                    o = status_beat(r.status);
                    o.value = r.value;
                    expected_beats.push_back(o);
                    if (r.status == ST_OK) begin
                        if (hist_count < HISTORY_DEPTH) begin
                            hist_ring[(hist_head + hist_count) % HISTORY_DEPTH] =
                                '{a: c.operand_a, b: c.operand_b, op: c.op_code};
                            hist_count++;
                        end else begin
                            hist_ring[hist_head] =
                                '{a: c.operand_a, b: c.operand_b, op: c.op_code};
                            hist_head = (hist_head + 1) % HISTORY_DEPTH;
                        end
                    end
                end
            end
            CMD_REPLAY: begin
                if (c.replay_index < 1 || c.replay_index > hist_count)
                    expected_beats.push_back(status_beat(ST_BADIDX));
                else
                    expected_beats.push_back(entry_beat(c.replay_index, 1'b1));
            end
            CMD_CLEAR: begin
                hist_count = 0;
                hist_head = 0;
                expected_beats.push_back(status_beat(ST_DONE));
            end
            default: begin
                if (hist_count == 0)
                    expected_beats.push_back(status_beat(ST_EMPTY));
                for (int p = 1; p <= hist_count; p++)
                    expected_beats.push_back(entry_beat(p, p == hist_count));
            end
        endcase
    endtask

    function automatic t_in_beat make_beat(logic [CMD_W-1:0] cmd,
                                           logic signed [DATA_W-1:0] a,
                                           logic [OP_W-1:0] op,
                                           logic signed [DATA_W-1:0] b,
                                           logic [IDX_W-1:0] idx);
        t_in_beat c;
        c.cmd = cmd;
        c.operand_a = a;
        c.op_code = op;
        c.operand_b = b;
        c.replay_index = idx;
        return c;
    endfunction

    // Present one command beat and wait until it is taken. Valid stays high
    // after the handshake; the next call or the caller lowers it.
    task automatic send_beat(t_in_beat c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= c;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_results(c);
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        $display("MISMATCH beat %0d field %s: got 0x%0h, expected 0x%0h",
                 beats_checked, field, got, want);
        mismatches++;
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_beats.size() == 0) begin
                report_mismatch("unexpected beat", o_out_data.value, '0);
            end else begin
                want = expected_beats.pop_front();
                if (o_out_data.value !== want.value)
                    report_mismatch("value", o_out_data.value, want.value);
                if (o_out_data.status !== want.status)
                    report_mismatch("status", o_out_data.status, want.status);
                if (o_out_data.entry_a !== want.entry_a)
                    report_mismatch("entry_a", o_out_data.entry_a, want.entry_a);
                if (o_out_data.entry_op !== want.entry_op)
                    report_mismatch("entry_op", o_out_data.entry_op, want.entry_op);
                if (o_out_data.entry_b !== want.entry_b)
                    report_mismatch("entry_b", o_out_data.entry_b, want.entry_b);
                if (o_out_data.entry_pos !== want.entry_pos)
                    report_mismatch("entry_pos", o_out_data.entry_pos, want.entry_pos);
                if (o_out_data.last !== want.last)
                    report_mismatch("last", o_out_data.last, want.last);
            end
            beats_checked++;
        end
    end

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog on cycles with no beat moving on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return -1;
            2: return INT_MIN;
            3: return INT_MAX;
            4, 5: return $signed($urandom_range(0, 40)) - 20;
            default: return $urandom;
        endcase
    endfunction

    // List and replay on an empty history.
    task automatic test_empty_history();
        send_beat(make_beat(CMD_LIST, 0, OP_ADD, 0, 0));
        send_beat(make_beat(CMD_REPLAY, 0, OP_ADD, 0, 8'd1));
    endtask

    // Wrap, truncation, the minimum over minus one, zero divisors, bad opcodes.
    task automatic test_arith_edges();
        send_beat(make_beat(CMD_COMPUTE, INT_MIN, OP_DIV, -1, 0));
        send_beat(make_beat(CMD_COMPUTE, INT_MIN, OP_REM, -1, 0));
        send_beat(make_beat(CMD_COMPUTE, INT_MAX, OP_ADD, 1, 0));
        send_beat(make_beat(CMD_COMPUTE, INT_MIN, OP_SUB, 1, 0));
        send_beat(make_beat(CMD_COMPUTE, INT_MAX, OP_MUL, INT_MAX, 0));
        send_beat(make_beat(CMD_COMPUTE, -7, OP_DIV, 2, 0));
        send_beat(make_beat(CMD_COMPUTE, -7, OP_REM, 2, 8'hFF));
        send_beat(make_beat(CMD_COMPUTE, 5, OP_DIV, 0, 0));
        send_beat(make_beat(CMD_COMPUTE, -1, OP_REM, 0, 0));
        send_beat(make_beat(CMD_COMPUTE, 3, 3'd5, 4, 0));
        send_beat(make_beat(CMD_COMPUTE, -1, 3'd7, -1, 8'hFF));
    endtask

    // Replay at both ends of the history and just past it, then list it all.
    task automatic test_replay_and_list();
        send_beat(make_beat(CMD_REPLAY, 0, OP_ADD, 0, 8'd1));
        send_beat(make_beat(CMD_REPLAY, 0, OP_ADD, 0, IDX_W'(hist_count)));
        send_beat(make_beat(CMD_REPLAY, 0, OP_ADD, 0, IDX_W'(hist_count + 1)));
        send_beat(make_beat(CMD_REPLAY, 0, OP_ADD, 0, 8'd0));
        send_beat(make_beat(CMD_REPLAY, -1, 3'd7, -1, 8'hFF));
        send_beat(make_beat(CMD_LIST, 0, OP_ADD, 0, 0));
    endtask

    task automatic test_clear();
        send_beat(make_beat(CMD_CLEAR, -1, 3'd7, -1, 8'hFF));
        send_beat(make_beat(CMD_LIST, 0, OP_ADD, 0, 0));
    endtask

    // Mostly computes and replays with valid positions, so the history fills
    // and wraps; lists, clears and fully random beats mixed in.
    task automatic test_random_traffic(int n_items);
        t_in_beat c;
        int       pick;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            c = make_beat(CMD_COMPUTE, pick_operand(), OP_ADD, pick_operand(),
                          IDX_W'($urandom));
            if (pick < 55) begin
                c.op_code = ($urandom_range(0, 99) < 6) ? OP_W'($urandom_range(5, 7))
                                                         : OP_W'($urandom_range(0, 4));
            end else if (pick < 77) begin
                c.cmd = CMD_REPLAY;
                c.op_code = OP_W'($urandom);
                if ($urandom_range(0, 99) < 75)
                    c.replay_index = IDX_W'($urandom_range(0, hist_count + 1));
            end else if (pick < 90) begin
                c.cmd = CMD_LIST;
            end else if (pick < 95) begin
                c.cmd = CMD_CLEAR;
            end else begin
                c = make_beat(CMD_W'($urandom), $urandom, OP_W'($urandom), $urandom,
                              IDX_W'($urandom));
            end
            send_beat(c);
        end
    endtask

    initial begin
        hist_head = 0;
        hist_count = 0;
        mismatches = 0;
        beats_checked = 0;
        cmd_seen = '{default: 0};
        quiet_cycles = 0;
        send_idle_pct = 26;
        recv_idle_pct = 62;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_history();
        test_arith_edges();
        test_replay_and_list();
        test_clear();
        test_random_traffic(100);

        send_idle_pct = 62;
        recv_idle_pct = 26;
        test_random_traffic(100);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(100);

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d compute, %0d replay, %0d clear and %0d list commands.",
                 cmd_seen[CMD_COMPUTE], cmd_seen[CMD_REPLAY], cmd_seen[CMD_CLEAR],
                 cmd_seen[CMD_LIST]);
        $display("Checked %0d result beats under three back-pressure mixes.",
                 beats_checked);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
